/* hw/rtl/gfs_pkg.sv */
`timescale 1ns / 1ps

package gfs_pkg;

    localparam int ROW_W = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef logic [ROW_W-1:0] t_row;

    // beat moving down the cell chain
    typedef struct packed {
        logic tok;
        logic rhs;
        t_row bits;
    } t_beat;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic en;       // store a new pivot row, back-eliminate the others
        logic clr;      // drop all pivot rows
        logic collect;  // chain beat gathers the solution instead of reducing
        logic rhs;
        t_row bits;
        t_row piv;      // one-hot pivot column of the new row
    } t_upd;

endpackage

/* hw/rtl/gfs_cell.sv */
`timescale 1ns / 1ps

module gfs_cell import gfs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_beat i_beat,
    input  t_upd  i_upd,
    input  logic  i_prev_occ,
    output t_beat o_beat,
    output logic  o_occ
);

    logic r_occ;
    t_row r_row;
    logic r_rhs;
    t_row r_piv;
    logic r_tok;
    t_row r_bits;
    logic r_brhs;

    logic hit;
    logic elim;
    logic wr;
    t_row n_bits;
    logic n_brhs;

    always_comb begin
        hit  = r_occ & (|(i_beat.bits & r_piv));
        elim = i_upd.en & r_occ & (|(r_row & i_upd.piv));
        // first free cell of the chain takes the new row
        wr   = i_upd.en & ~r_occ & i_prev_occ;
        if (i_upd.collect) begin
            n_bits = i_beat.bits | ((r_occ & r_rhs) ? r_piv : '0);
            n_brhs = i_beat.rhs;
        end else begin
            n_bits = hit ? (i_beat.bits ^ r_row) : i_beat.bits;
            n_brhs = i_beat.rhs ^ (hit & r_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_beat.tok;
            if (i_upd.clr) begin
                r_occ <= 1'b0;
            end else if (wr) begin
                r_occ <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_brhs <= n_brhs;
        if (wr) begin
            r_row <= i_upd.bits;
            r_rhs <= i_upd.rhs;
            r_piv <= i_upd.piv;
        end else if (elim) begin
            r_row <= r_row ^ i_upd.bits;
            r_rhs <= r_rhs ^ i_upd.rhs;
        end
    end

    assign o_beat = '{tok: r_tok, rhs: r_brhs, bits: r_bits};
    assign o_occ  = r_occ;

endmodule

/* hw/rtl/gf2_linear_system_solver.sv */
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------
// input    | in        | i_valid / o_ready  | i_row_bits, i_rhs_bit, i_last_row
// result   | out       | o_valid / i_ready  | o_solution, o_feasible
// config   | in        | i_cfg_we           | i_cfg_data (column count)
//
// One row at a time: a row walks the chain of MAX_COLUMNS cells, one cell per
// cycle, and the next row is taken only after it has left the chain.
// A consistent last row adds a second chain walk to gather the solution before
// the result beat is offered.
// Rows after an inconsistent one are dropped without a chain walk.
// Synchronous active-low reset empties the store; a stalled result blocks input.

module gf2_linear_system_solver import gfs_pkg::*; #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ROW_W-1:0] i_row_bits,
    input  logic             i_rhs_bit,
    input  logic             i_last_row,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ROW_W-1:0] o_solution,
    output logic             o_feasible,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RUN     = 5'b00010,
        S_COLL_GO = 5'b00100,
        S_COLL    = 5'b01000,
        S_FIN     = 5'b10000
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_col_cnt;
    logic             r_incons;
    logic             r_last;
    t_row             r_res;
    logic             r_res_feas;
    logic             r_out_valid;
    t_row             r_solution;
    logic             r_feasible;

    t_beat beat [0:MAX_COLUMNS];
    logic  occ  [0:MAX_COLUMNS];
    t_upd  upd;

    logic [CFG_W-1:0] col_sat;
    t_row             mask;
    logic             accept;
    logic             emerge;
    logic             red_zero;
    logic             fin_load;
    t_beat            chain_out;

    always_comb begin
        col_sat = (r_col_cnt > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : r_col_cnt;
        for (int k = 0; k < ROW_W; k++) begin
            mask[k] = (CFG_W'(k) < col_sat);
        end
    end

    assign chain_out = beat[MAX_COLUMNS];
    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid & o_ready;
    assign emerge    = (r_state == S_RUN) & chain_out.tok;
    assign red_zero  = (chain_out.bits == '0);
    assign fin_load  = (r_state == S_FIN) & (~r_out_valid | i_ready);

    assign beat[0] = '{tok:  (accept & ~r_incons) | (r_state == S_COLL_GO),
                       rhs:  i_rhs_bit,
                       bits: (r_state == S_COLL_GO) ? t_row'(0) : (i_row_bits & mask)};
    assign occ[0]  = 1'b1;

    always_comb begin
        upd.en      = emerge & ~red_zero & ~occ[MAX_COLUMNS];
        upd.clr     = fin_load;
        upd.collect = (r_state == S_COLL_GO) | (r_state == S_COLL);
        upd.rhs     = chain_out.rhs;
        upd.bits    = chain_out.bits;
        // isolate lowest set bit
        upd.piv     = chain_out.bits & (~chain_out.bits + t_row'(1));
    end

    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
        gfs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_beat     (beat[g]),
            .i_upd      (upd),
            .i_prev_occ (occ[g]),
            .o_beat     (beat[g+1]),
            .o_occ      (occ[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col_cnt   <= CFG_RESET;
            r_incons    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_col_cnt <= i_cfg_data;
            end

            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!r_incons) begin
                            r_state <= S_RUN;
                        end else if (i_last_row) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RUN: begin
                    if (emerge) begin
                        if (red_zero && chain_out.rhs) begin
                            r_incons <= 1'b1;
                            r_state  <= r_last ? S_FIN : S_IDLE;
                        end else begin
                            r_state  <= r_last ? S_COLL_GO : S_IDLE;
                        end
                    end
                end
                S_COLL_GO: begin
                    r_state <= S_COLL;
                end
                S_COLL: begin
                    if (chain_out.tok) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_incons <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_last_row;
        end
        if (accept && r_incons) begin
            r_res      <= '0;
            r_res_feas <= 1'b0;
        end else if (emerge && red_zero && chain_out.rhs) begin
            r_res      <= '0;
            r_res_feas <= 1'b0;
        end else if ((r_state == S_COLL) && chain_out.tok) begin
            r_res      <= chain_out.bits;
            r_res_feas <= 1'b1;
        end
        if (fin_load) begin
            r_solution <= r_res;
            r_feasible <= r_res_feas;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_solution = r_solution;
    assign o_feasible = r_feasible;

endmodule
